// File: hdl/rie_pkg.sv
// Shared types, constants and decode helpers of the instruction executor.
package rie_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW = $clog2(MEM_BYTES);
	localparam int APB_AW = 3;
	localparam logic [APB_AW-3:0] REG_START_PC = '0;
	localparam logic [31:0] START_PC_RESET = 32'h4000_0000;
	localparam int DIV_STEPS = 32;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_EXEC = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [3:0] SP_IDX = 4'd14;
	localparam logic [3:0] PC_IDX = 4'd15;
	localparam logic [1:0] CSR_STATUS = 2'd0;
	localparam logic [1:0] CSR_HANDLER = 2'd1;
	localparam logic [1:0] CSR_CAUSE = 2'd2;
	localparam logic [3:0] CSR_COUNT = 4'd3;
	localparam logic [31:0] CAUSE_ILLEGAL = 32'd1;
	localparam logic [31:0] CAUSE_SWI = 32'd4;

	localparam logic [3:0] OP_HALT = 4'd0;
	localparam logic [3:0] OP_SWI = 4'd1;
	localparam logic [3:0] OP_CALL = 4'd2;
	localparam logic [3:0] OP_JUMP = 4'd3;
	localparam logic [3:0] OP_XCHG = 4'd4;
	localparam logic [3:0] OP_ARITH = 4'd5;
	localparam logic [3:0] OP_LOGIC = 4'd6;
	localparam logic [3:0] OP_SHIFT = 4'd7;
	localparam logic [3:0] OP_STORE = 4'd8;
	localparam logic [3:0] OP_LOAD = 4'd9;

	localparam logic [3:0] MD_CALL_REG = 4'd0;
	localparam logic [3:0] MD_CALL_MEM = 4'd1;
	localparam logic [1:0] CND_ALWAYS = 2'd0;
	localparam logic [1:0] CND_EQ = 2'd1;
	localparam logic [1:0] CND_NE = 2'd2;
	localparam logic [1:0] CND_GT = 2'd3;
	localparam logic [3:0] MD_ADD = 4'd0;
	localparam logic [3:0] MD_SUB = 4'd1;
	localparam logic [3:0] MD_MUL = 4'd2;
	localparam logic [3:0] MD_DIV = 4'd3;
	localparam logic [3:0] MD_NOT = 4'd0;
	localparam logic [3:0] MD_AND = 4'd1;
	localparam logic [3:0] MD_OR = 4'd2;
	localparam logic [3:0] MD_XOR = 4'd3;
	localparam logic [3:0] MD_SHL = 4'd0;
	localparam logic [3:0] MD_SAR = 4'd1;
	localparam logic [3:0] MD_ST_DIR = 4'd0;
	localparam logic [3:0] MD_ST_PRE = 4'd1;
	localparam logic [3:0] MD_ST_IND = 4'd2;
	localparam logic [2:0] MD_LD_CSR = 3'd0;
	localparam logic [2:0] MD_LD_ADDI = 3'd1;
	localparam logic [2:0] MD_LD_IDX = 3'd2;
	localparam logic [2:0] MD_LD_POST = 3'd3;
	localparam logic [2:0] MD_CSR_WR = 3'd4;
	localparam logic [2:0] MD_CSR_OR = 3'd5;
	localparam logic [2:0] MD_CSR_IDX = 3'd6;
	localparam logic [2:0] MD_CSR_POST = 3'd7;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] address;
		logic [31:0] data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [31:0] program_counter;
		logic        halted;
		logic        faulted;
	} out_item_t;

	typedef enum logic [5:0] {
		STEP_NOP, STEP_CLR, STEP_ACCEPT, STEP_MWR, STEP_MRD, STEP_DECODE,
		STEP_PUSH_ST, STEP_PUSH_PC, STEP_SWI, STEP_RDA, STEP_RDB, STEP_RDC,
		STEP_CALL, STEP_PC_AD, STEP_PC_MDR, STEP_EA_AB, STEP_EA_A, STEP_EA_BC,
		STEP_EA_B, STEP_EA_MDR, STEP_ST1, STEP_SWAP1, STEP_SWAP2, STEP_ALU,
		STEP_DIVINIT, STEP_DIVSTEP, STEP_DIVWB, STEP_CSR2A, STEP_ADDB,
		STEP_MDR2A, STEP_BINC, STEP_CSRW_B, STEP_CSRW_OR, STEP_CSRW_MDR,
		STEP_FIN
	} step_t;

	typedef struct packed {
		step_t      step;
		logic [1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] md;
		logic       ill;
		logic       take;
		logic       stopped;
		logic       clr_last;
	} sts_t;

	function automatic logic is_illegal(input logic [3:0] op, input logic [3:0] md);
		logic ill;
		ill = 1'b0;
		unique case (op)
			OP_HALT, OP_SWI, OP_XCHG: ill = 1'b0;
			OP_CALL:  ill = (md > MD_CALL_MEM);
			OP_JUMP:  ill = md[2];
			OP_ARITH: ill = (md > MD_DIV);
			OP_LOGIC: ill = (md > MD_XOR);
			OP_SHIFT: ill = (md > MD_SAR);
			OP_STORE: ill = (md > MD_ST_IND);
			OP_LOAD:  ill = md[3];
			default:  ill = 1'b1;
		endcase
		return ill;
	endfunction

endpackage

// File: hdl/rie_ram.sv
// Generic single-port RAM with registered read.
module rie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule

// File: hdl/rie_ctrl.sv
// Sequencer of the executor: steps the datapath through each item.
module rie_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    mode,
	output logic          busy,
	output logic          done,
	output rie_pkg::cmd_t cmd,
	input  rie_pkg::sts_t sts
);
	import rie_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_CLR = 5'd1;
	localparam logic [4:0] ST_DONE = 5'd2;
	localparam logic [4:0] ST_MWR = 5'd3;
	localparam logic [4:0] ST_MRD = 5'd4;
	localparam logic [4:0] ST_DECODE = 5'd5;
	localparam logic [4:0] ST_DISPATCH = 5'd6;
	localparam logic [4:0] ST_PUSH_ST = 5'd7;
	localparam logic [4:0] ST_PUSH_PC = 5'd8;
	localparam logic [4:0] ST_SWI = 5'd9;
	localparam logic [4:0] ST_RDA = 5'd10;
	localparam logic [4:0] ST_RDB = 5'd11;
	localparam logic [4:0] ST_RDC = 5'd12;
	localparam logic [4:0] ST_EXEC = 5'd13;
	localparam logic [4:0] ST_SWAP2 = 5'd14;
	localparam logic [4:0] ST_DIV = 5'd15;
	localparam logic [4:0] ST_DIVWB = 5'd16;
	localparam logic [4:0] ST_PCMDR = 5'd17;
	localparam logic [4:0] ST_EAMDR = 5'd18;
	localparam logic [4:0] ST_MDR2A = 5'd19;
	localparam logic [4:0] ST_CSRMDR = 5'd20;
	localparam logic [4:0] ST_BINC = 5'd21;
	localparam logic [4:0] ST_FIN = 5'd22;

	logic [4:0] state_q, state_d, ret_q, ret_d;
	logic [4:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			ret_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		cnt_d = cnt_q;
		cmd.step = STEP_NOP;
		cmd.idx = cnt_q[1:0];
		unique case (state_q)
			ST_CLR: begin
				cmd.step = STEP_CLR;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cnt_d = '0;
				if (start) begin
					cmd.step = STEP_ACCEPT;
					if (mode == MODE_LOAD) begin
						state_d = ST_MWR;
						ret_d = ST_DONE;
					end else if (mode == MODE_EXEC && !sts.stopped) begin
						state_d = ST_MRD;
						ret_d = ST_DECODE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MWR: begin
				cmd.step = STEP_MWR;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q[1:0] == 2'd3) begin
					cnt_d = '0;
					state_d = ret_q;
				end
			end
			ST_MRD: begin
				// four byte reads, then a wait state while the last byte lands
				if (!cnt_q[2]) begin
					cmd.step = STEP_MRD;
					cnt_d = cnt_q + 5'd1;
				end else begin
					cnt_d = '0;
					state_d = ret_q;
				end
			end
			ST_DECODE: begin
				cmd.step = STEP_DECODE;
				state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (sts.ill || sts.op == OP_HALT) state_d = ST_FIN;
				else if (sts.op == OP_SWI) state_d = ST_PUSH_ST;
				else if (sts.op == OP_CALL) state_d = ST_PUSH_PC;
				else state_d = ST_RDA;
			end
			ST_PUSH_ST: begin
				cmd.step = STEP_PUSH_ST;
				state_d = ST_MWR;
				ret_d = ST_PUSH_PC;
			end
			ST_PUSH_PC: begin
				cmd.step = STEP_PUSH_PC;
				state_d = ST_MWR;
				ret_d = (sts.op == OP_SWI) ? ST_SWI : ST_RDA;
			end
			ST_SWI: begin
				cmd.step = STEP_SWI;
				state_d = ST_FIN;
			end
			ST_RDA: begin
				cmd.step = STEP_RDA;
				state_d = ST_RDB;
			end
			ST_RDB: begin
				cmd.step = STEP_RDB;
				state_d = ST_RDC;
			end
			ST_RDC: begin
				cmd.step = STEP_RDC;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_FIN;
				unique case (sts.op)
					OP_CALL: begin
						if (sts.md == MD_CALL_REG) begin
							cmd.step = STEP_CALL;
						end else begin
							cmd.step = STEP_EA_AB;
							state_d = ST_MRD;
							ret_d = ST_PCMDR;
						end
					end
					OP_JUMP: begin
						if (sts.take && sts.md[3]) begin
							cmd.step = STEP_EA_A;
							state_d = ST_MRD;
							ret_d = ST_PCMDR;
						end else if (sts.take) begin
							cmd.step = STEP_PC_AD;
						end
					end
					OP_XCHG: begin
						cmd.step = STEP_SWAP1;
						state_d = ST_SWAP2;
					end
					OP_ARITH: begin
						if (sts.md == MD_DIV) begin
							cmd.step = STEP_DIVINIT;
							state_d = ST_DIV;
						end else begin
							cmd.step = STEP_ALU;
						end
					end
					OP_LOGIC, OP_SHIFT: cmd.step = STEP_ALU;
					OP_STORE: begin
						if (sts.md == MD_ST_DIR) begin
							cmd.step = STEP_EA_AB;
							state_d = ST_MWR;
							ret_d = ST_FIN;
						end else if (sts.md == MD_ST_PRE) begin
							cmd.step = STEP_ST1;
							state_d = ST_MWR;
							ret_d = ST_FIN;
						end else begin
							cmd.step = STEP_EA_AB;
							state_d = ST_MRD;
							ret_d = ST_EAMDR;
						end
					end
					OP_LOAD: begin
						unique case (sts.md[2:0])
							MD_LD_CSR:  cmd.step = STEP_CSR2A;
							MD_LD_ADDI: cmd.step = STEP_ADDB;
							MD_LD_IDX, MD_LD_POST: begin
								cmd.step = (sts.md[2:0] == MD_LD_IDX) ? STEP_EA_BC : STEP_EA_B;
								state_d = ST_MRD;
								ret_d = ST_MDR2A;
							end
							MD_CSR_WR: cmd.step = STEP_CSRW_B;
							MD_CSR_OR: cmd.step = STEP_CSRW_OR;
							default: begin
								cmd.step = (sts.md[2:0] == MD_CSR_IDX) ? STEP_EA_BC : STEP_EA_B;
								state_d = ST_MRD;
								ret_d = ST_CSRMDR;
							end
						endcase
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_SWAP2: begin
				cmd.step = STEP_SWAP2;
				state_d = ST_FIN;
			end
			ST_DIV: begin
				cmd.step = STEP_DIVSTEP;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					cnt_d = '0;
					state_d = ST_DIVWB;
				end
			end
			ST_DIVWB: begin
				cmd.step = STEP_DIVWB;
				state_d = ST_FIN;
			end
			ST_PCMDR: begin
				cmd.step = STEP_PC_MDR;
				state_d = ST_FIN;
			end
			ST_EAMDR: begin
				cmd.step = STEP_EA_MDR;
				state_d = ST_MWR;
				ret_d = ST_FIN;
			end
			ST_MDR2A: begin
				cmd.step = STEP_MDR2A;
				state_d = (sts.md[2:0] == MD_LD_POST) ? ST_BINC : ST_FIN;
			end
			ST_CSRMDR: begin
				cmd.step = STEP_CSRW_MDR;
				state_d = (sts.md[2:0] == MD_CSR_POST) ? ST_BINC : ST_FIN;
			end
			ST_BINC: begin
				cmd.step = STEP_BINC;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.step = STEP_FIN;
				state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
endmodule

// File: hdl/rie_dp.sv
// Datapath: register files, flags, byte memory port, ALU and divider.
module rie_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rie_pkg::cmd_t       cmd,
	output rie_pkg::sts_t       sts,
	input  rie_pkg::in_item_t   req,
	input  logic                cfg_wr,
	input  logic [31:0]         cfg_wdata,
	output logic [31:0]         start_pc,
	output rie_pkg::out_item_t  rsp
);
	import rie_pkg::*;

	logic [31:0] gpr_q [16];
	logic [31:0] csr_q [3];
	logic        halted_q, faulted_q;
	logic [31:0] start_pc_q;
	logic [MEM_AW-1:0] clr_q;
	logic        rd_pend_q;
	logic [1:0]  rd_idx_q;
	logic [31:0] ir_q, mdr_q, addr_q, wdata_q, ra_q, rb_q, rc_q, rv_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic        neg_q, dz_q;

	logic [3:0]  op, md, fa, fb, fc, rsel;
	logic [31:0] disp, rport, alu, csr_b, cur_sp, sp_dec, div_res, binc_base;
	logic        ill, take;
	logic [32:0] div_sh;
	logic        div_ge;
	logic [MEM_AW-1:0] ram_addr;
	logic        ram_we;
	logic [7:0]  ram_wd, ram_rd;

	assign op = ir_q[31:28];
	assign md = ir_q[27:24];
	assign fa = ir_q[23:20];
	assign fb = ir_q[19:16];
	assign fc = ir_q[15:12];
	assign disp = {{20{ir_q[11]}}, ir_q[11:0]};
	assign ill = is_illegal(op, md);
	assign cur_sp = gpr_q[SP_IDX];
	assign sp_dec = cur_sp - 32'd4;
	assign csr_b = (fb < CSR_COUNT) ? csr_q[fb[1:0]] : '0;
	assign binc_base = (md[2:0] == MD_LD_POST && fa == fb) ? mdr_q : rb_q;

	always_comb begin
		unique case (cmd.step)
			STEP_RDA:    rsel = fa;
			STEP_RDB:    rsel = fb;
			STEP_RDC:    rsel = fc;
			STEP_ACCEPT: rsel = req.address[3:0];
			default:     rsel = fa;
		endcase
	end
	assign rport = gpr_q[rsel];

	always_comb begin
		unique case (md[1:0])
			CND_ALWAYS: take = 1'b1;
			CND_EQ:     take = (rb_q == rc_q);
			CND_NE:     take = (rb_q != rc_q);
			default:    take = ($signed(rb_q) > $signed(rc_q));
		endcase
	end

	always_comb begin
		alu = '0;
		unique case (op)
			OP_ARITH: begin
				if (md == MD_ADD) alu = rb_q + rc_q;
				else if (md == MD_SUB) alu = rb_q - rc_q;
				else alu = rb_q * rc_q;
			end
			OP_LOGIC: begin
				if (md == MD_NOT) alu = ~rb_q;
				else if (md == MD_AND) alu = rb_q & rc_q;
				else if (md == MD_OR) alu = rb_q | rc_q;
				else alu = rb_q ^ rc_q;
			end
			OP_SHIFT: begin
				if (md == MD_SHL) alu = rb_q << rc_q[4:0];
				else alu = 32'($signed(rb_q) >>> rc_q[4:0]);
			end
			default: alu = '0;
		endcase
	end

	// one quotient bit per cycle, restoring
	assign div_sh = {rem_q, quo_q[31]};
	assign div_ge = (div_sh >= {1'b0, dvs_q});
	assign div_res = dz_q ? '0 : (neg_q ? (32'd0 - quo_q) : quo_q);

	// memory address wraps modulo the memory size
	assign ram_we = (cmd.step == STEP_CLR) || (cmd.step == STEP_MWR);
	assign ram_addr = (cmd.step == STEP_CLR) ? clr_q : (addr_q[MEM_AW-1:0] + MEM_AW'(cmd.idx));
	assign ram_wd = (cmd.step == STEP_CLR) ? 8'd0 : wdata_q[8*cmd.idx +: 8];

	rie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wd),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cmd.step == STEP_CLR) clr_q <= clr_q + MEM_AW'(1);
			rd_pend_q <= (cmd.step == STEP_MRD);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) gpr_q[i] <= '0;
			for (int i = 0; i < 3; i++) csr_q[i] <= '0;
			gpr_q[PC_IDX] <= START_PC_RESET;
			start_pc_q <= START_PC_RESET;
			halted_q <= 1'b0;
			faulted_q <= 1'b0;
		end else begin
			unique case (cmd.step)
				STEP_DECODE: gpr_q[PC_IDX] <= gpr_q[PC_IDX] + 32'd4;
				STEP_PUSH_ST, STEP_PUSH_PC: gpr_q[SP_IDX] <= sp_dec;
				STEP_SWI: begin
					csr_q[CSR_CAUSE] <= CAUSE_SWI;
					csr_q[CSR_STATUS] <= csr_q[CSR_STATUS] & ~32'd1;
					gpr_q[PC_IDX] <= csr_q[CSR_HANDLER];
				end
				STEP_CALL:   gpr_q[PC_IDX] <= ra_q + rb_q + disp;
				STEP_PC_AD:  gpr_q[PC_IDX] <= ra_q + disp;
				STEP_PC_MDR: gpr_q[PC_IDX] <= mdr_q;
				STEP_ST1:    gpr_q[fa] <= ra_q + disp;
				STEP_SWAP1:  gpr_q[fb] <= rc_q;
				STEP_SWAP2:  gpr_q[fc] <= rb_q;
				STEP_ALU:    gpr_q[fa] <= alu;
				STEP_DIVWB:  gpr_q[fa] <= div_res;
				STEP_CSR2A:  gpr_q[fa] <= csr_b;
				STEP_ADDB:   gpr_q[fa] <= rb_q + disp;
				STEP_MDR2A:  gpr_q[fa] <= mdr_q;
				STEP_BINC:   gpr_q[fb] <= binc_base + disp;
				STEP_CSRW_B: if (fa < CSR_COUNT) csr_q[fa[1:0]] <= rb_q;
				STEP_CSRW_OR: if (fa < CSR_COUNT) csr_q[fa[1:0]] <= csr_b | disp;
				STEP_CSRW_MDR: if (fa < CSR_COUNT) csr_q[fa[1:0]] <= mdr_q;
				STEP_FIN: begin
					if (ill) csr_q[CSR_CAUSE] <= CAUSE_ILLEGAL;
					gpr_q[0] <= '0;
					if (op == OP_HALT) halted_q <= 1'b1;
					if (ill || csr_q[CSR_CAUSE] == CAUSE_ILLEGAL) faulted_q <= 1'b1;
				end
				default: ;
			endcase
			if (cfg_wr) begin
				start_pc_q <= cfg_wdata;
				gpr_q[PC_IDX] <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) mdr_q[8*rd_idx_q +: 8] <= ram_rd;
		rd_idx_q <= cmd.idx;
		unique case (cmd.step)
			STEP_ACCEPT: begin
				addr_q <= (req.mode == MODE_EXEC) ? gpr_q[PC_IDX] : req.address;
				wdata_q <= req.data;
				if (req.mode != MODE_READ) rv_q <= '0;
				else if (req.address < 32'd16) rv_q <= rport;
				else if (req.address < 32'd19) rv_q <= csr_q[req.address[1:0]];
				else rv_q <= '0;
			end
			STEP_DECODE: ir_q <= mdr_q;
			STEP_PUSH_ST: begin
				addr_q <= sp_dec;
				wdata_q <= csr_q[CSR_STATUS];
			end
			STEP_PUSH_PC: begin
				addr_q <= sp_dec;
				wdata_q <= gpr_q[PC_IDX];
			end
			STEP_RDA: ra_q <= rport;
			STEP_RDB: rb_q <= rport;
			STEP_RDC: rc_q <= rport;
			STEP_EA_AB: begin
				addr_q <= ra_q + rb_q + disp;
				wdata_q <= rc_q;
			end
			STEP_EA_A:   addr_q <= ra_q + disp;
			STEP_EA_BC:  addr_q <= rb_q + rc_q + disp;
			STEP_EA_B:   addr_q <= rb_q;
			STEP_EA_MDR: addr_q <= mdr_q;
			STEP_ST1: begin
				addr_q <= ra_q + disp;
				wdata_q <= (fc == fa) ? (ra_q + disp) : rc_q;
			end
			STEP_DIVINIT: begin
				quo_q <= rb_q[31] ? (32'd0 - rb_q) : rb_q;
				dvs_q <= rc_q[31] ? (32'd0 - rc_q) : rc_q;
				rem_q <= '0;
				neg_q <= rb_q[31] ^ rc_q[31];
				dz_q <= (rc_q == '0);
			end
			STEP_DIVSTEP: begin
				rem_q <= div_ge ? 32'(div_sh - {1'b0, dvs_q}) : div_sh[31:0];
				quo_q <= {quo_q[30:0], div_ge};
			end
			default: ;
		endcase
	end

	assign sts.op = op;
	assign sts.md = md;
	assign sts.ill = ill;
	assign sts.take = take;
	assign sts.stopped = halted_q | faulted_q;
	assign sts.clr_last = (clr_q == MEM_AW'(MEM_BYTES - 1));

	assign start_pc = start_pc_q;
	assign rsp.read_value = rv_q;
	assign rsp.program_counter = gpr_q[PC_IDX];
	assign rsp.halted = halted_q;
	assign rsp.faulted = faulted_q;
endmodule

// File: hdl/risc_instruction_executor.sv
// Top level of the instruction executor: sequencer, datapath and config port.
//
//   channel   signals                        beat taken when
//   item in   start, busy, req               start high and busy low
//   result    done, rsp                      done high (one cycle, no stall)
//   config    psel, penable, pwrite, paddr   psel, penable, pwrite, pready high
//
// After reset the byte memory is cleared, one byte a cycle, with busy high;
// config writes are taken meanwhile.
// Instruction time is set by the single byte-wide memory port, which reads and
// writes each word one byte at a time; a divide also runs the bit-serial divider.
// Each result is shown for exactly one cycle with done.
module risc_instruction_executor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  rie_pkg::in_item_t           req,
	output logic                        done,
	output rie_pkg::out_item_t          rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rie_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import rie_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic        reg_hit, cfg_wr;
	logic [31:0] start_pc;

	assign reg_hit = (paddr[APB_AW-1:2] == REG_START_PC);
	assign cfg_wr = psel & penable & pwrite & reg_hit;
	assign pready = 1'b1;
	assign prdata = reg_hit ? start_pc : '0;

	rie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (req.mode),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	rie_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_wr    (cfg_wr),
		.cfg_wdata (pwdata),
		.start_pc  (start_pc),
		.rsp       (rsp)
	);
endmodule

// File: hdl/rie_chk.sv
// Port-level checks of the executor's command handshake, bound to the top.
module rie_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat while not busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("not ready after result beat");
endmodule

bind risc_instruction_executor rie_chk u_rie_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
